// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define BMP_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("check failed");

// Consequent must hold in the cycle after the antecedent.
`define BMP_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/bmp_prd_pkg.sv -----
// Types and constants of the BMP pixel row decoder.
package bmp_prd_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int COLOR_W       = 24;
	localparam int DIM_W         = 13;
	localparam int COORD_W       = 12;
	localparam int RB_W          = 14;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
	localparam int CNT_W         = FIFO_AW + 1;

	typedef enum logic [1:0] {
		DEPTH_1  = 2'd0,
		DEPTH_4  = 2'd1,
		DEPTH_8  = 2'd2,
		DEPTH_24 = 2'd3
	} depth_t;

	typedef enum logic [1:0] {
		REG_DEPTH  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic {
		FUNC_PALETTE = 1'b0,
		FUNC_PIXEL   = 1'b1
	} func_t;

	typedef struct packed {
		logic               direct;
		logic [COLOR_W-1:0] rgb;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
		logic               done;
	} pix_t;

	typedef struct packed {
		logic [COLOR_W-1:0] rgb;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
		logic               done;
	} out_t;

endpackage

// ----- hdl/bmp_pixel_row_decoder_unit.sv -----
// BMP pixel row decoder: colour table, byte unpacker and pixel output queue.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  item     | item_valid/item_stall, func, palette_*,   | in
//           | data_byte                                 |
//  pixel    | pixel_valid/pixel_stall, red, green,      | out
//           | blue, pixel_row, pixel_column, flags      |
//  cfg      | cfg_we, cfg_index, cfg_data               | in
//
// One pixel per cycle while the output queue has room: a data byte yields 1, 2 or 8
// pixels (fewer at row end), set by the single read port of the colour table; three
// 24-bit bytes yield one pixel. Pixels pass the unpacker, lookup stage and queue.
// Reset clears counters and queue; the colour table holds garbage until written.
// A stalled pixel channel fills a 4-entry queue, then the unpacker and input stall.
module bmp_pixel_row_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  palette_blue,
	input  logic [7:0]  palette_green,
	input  logic [7:0]  palette_red,
	input  logic [7:0]  data_byte,
	output logic        pixel_valid,
	input  logic        pixel_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [11:0] pixel_row,
	output logic [11:0] pixel_column,
	output logic        last_of_byte,
	output logic        image_done
);

	`include "assert_macros.svh"

	// configuration
	bmp_prd_pkg::depth_t                 depth_q;
	logic [bmp_prd_pkg::DIM_W-1:0]       width_q;
	logic [bmp_prd_pkg::DIM_W-1:0]       height_q;

	// frame counters
	logic [bmp_prd_pkg::DIM_W-1:0]       col_q;
	logic [bmp_prd_pkg::COORD_W-1:0]     line_q;
	logic [bmp_prd_pkg::RB_W-1:0]        rbc_q;
	logic [15:0]                         partial_q;
	logic [1:0]                          phase_q;

	// unpacker
	logic                                unp_busy_q;
	logic [7:0]                          unp_sh_q;
	logic [3:0]                          unp_rem_q;
	logic [bmp_prd_pkg::COORD_W-1:0]     unp_col_q;
	logic [bmp_prd_pkg::COORD_W-1:0]     unp_row_q;
	logic                                unp_lastline_q;
	logic                                unp_direct_q;
	logic [bmp_prd_pkg::COLOR_W-1:0]     unp_rgb_q;
	bmp_prd_pkg::depth_t                 unp_mode_q;

	// lookup stage and output queue
	logic                                s1_valid_q;
	bmp_prd_pkg::pix_t                   s1_q;
	logic [bmp_prd_pkg::COLOR_W-1:0]     ram_rdata;
	bmp_prd_pkg::out_t                   fifo_q [bmp_prd_pkg::FIFO_DEPTH];
	logic [bmp_prd_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [bmp_prd_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [bmp_prd_pkg::CNT_W-1:0]       cnt_q;

	logic [bmp_prd_pkg::DIM_W-1:0]       w_eff;
	logic [bmp_prd_pkg::DIM_W-1:0]       h_eff;
	logic [bmp_prd_pkg::RB_W-1:0]        wx;
	logic [bmp_prd_pkg::RB_W-1:0]        rb_raw;
	logic [bmp_prd_pkg::RB_W-1:0]        rb_sum;
	logic [bmp_prd_pkg::RB_W-1:0]        row_bytes;
	logic [bmp_prd_pkg::RB_W-1:0]        rbc_next;
	logic [bmp_prd_pkg::DIM_W-1:0]       line_next;
	logic [bmp_prd_pkg::DIM_W-1:0]       rem;
	logic [3:0]                          per;
	logic [3:0]                          n_load;
	logic                                col_lt;
	logic                                item_fire;
	logic                                byte_fire;
	logic                                pal_we;
	logic                                load;
	logic                                space;
	logic                                issue;
	logic                                pop;
	logic [7:0]                          idx;
	bmp_prd_pkg::pix_t                   pix;
	bmp_prd_pkg::out_t                   head;

	always_comb begin
		if (width_q == '0) begin
			w_eff = bmp_prd_pkg::DIM_W'(1);
		end else if (width_q > bmp_prd_pkg::DIM_W'(bmp_prd_pkg::MAX_WIDTH)) begin
			w_eff = bmp_prd_pkg::DIM_W'(bmp_prd_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = bmp_prd_pkg::DIM_W'(1);
		end else if (height_q > bmp_prd_pkg::DIM_W'(bmp_prd_pkg::MAX_HEIGHT)) begin
			h_eff = bmp_prd_pkg::DIM_W'(bmp_prd_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign wx = bmp_prd_pkg::RB_W'(w_eff);

	always_comb begin
		unique case (depth_q)
			bmp_prd_pkg::DEPTH_1: begin
				rb_raw = (wx + bmp_prd_pkg::RB_W'(7)) >> 3;
				per    = 4'd8;
			end
			bmp_prd_pkg::DEPTH_4: begin
				rb_raw = (wx + bmp_prd_pkg::RB_W'(1)) >> 1;
				per    = 4'd2;
			end
			bmp_prd_pkg::DEPTH_8: begin
				rb_raw = wx;
				per    = 4'd1;
			end
			default: begin
				rb_raw = wx + (wx << 1);
				per    = 4'd1;
			end
		endcase
	end

	assign rb_sum    = rb_raw + bmp_prd_pkg::RB_W'(3);
	assign row_bytes = {rb_sum[bmp_prd_pkg::RB_W-1:2], 2'b00};
	assign rbc_next  = rbc_q + bmp_prd_pkg::RB_W'(1);
	assign line_next = {1'b0, line_q} + bmp_prd_pkg::DIM_W'(1);

	assign col_lt = col_q < w_eff;
	assign rem    = w_eff - col_q;
	assign n_load = (depth_q == bmp_prd_pkg::DEPTH_24) ? 4'd1 :
		(rem < bmp_prd_pkg::DIM_W'(per)) ? rem[3:0] : per;

	assign space = (cnt_q + bmp_prd_pkg::CNT_W'(s1_valid_q))
		< bmp_prd_pkg::CNT_W'(bmp_prd_pkg::FIFO_DEPTH);
	assign issue = unp_busy_q && space;

	assign item_stall = unp_busy_q && !(issue && unp_rem_q == 4'd1);
	assign item_fire  = item_valid && !item_stall;
	assign byte_fire  = item_fire && (func == bmp_prd_pkg::FUNC_PIXEL);
	assign pal_we     = item_fire && (func == bmp_prd_pkg::FUNC_PALETTE);
	assign load       = byte_fire && col_lt &&
		(depth_q != bmp_prd_pkg::DEPTH_24 || phase_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= bmp_prd_pkg::DEPTH_24;
			width_q   <= bmp_prd_pkg::DIM_W'(1);
			height_q  <= bmp_prd_pkg::DIM_W'(1);
			col_q     <= '0;
			line_q    <= '0;
			rbc_q     <= '0;
			partial_q <= '0;
			phase_q   <= '0;
		end else if (cfg_we && cfg_index inside {bmp_prd_pkg::REG_DEPTH,
				bmp_prd_pkg::REG_WIDTH, bmp_prd_pkg::REG_HEIGHT}) begin
			unique case (bmp_prd_pkg::reg_idx_t'(cfg_index))
				bmp_prd_pkg::REG_DEPTH:  depth_q  <= bmp_prd_pkg::depth_t'(cfg_data[1:0]);
				bmp_prd_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bmp_prd_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q     <= '0;
			line_q    <= '0;
			rbc_q     <= '0;
			partial_q <= '0;
			phase_q   <= '0;
		end else if (byte_fire) begin
			if (col_lt) begin
				if (depth_q == bmp_prd_pkg::DEPTH_24) begin
					case (phase_q)
						2'd0: begin
							partial_q <= {8'd0, data_byte};
							phase_q   <= 2'd1;
						end
						2'd1: begin
							partial_q[15:8] <= data_byte;
							phase_q         <= 2'd2;
						end
						default: begin
							partial_q <= '0;
							phase_q   <= 2'd0;
							col_q     <= col_q + bmp_prd_pkg::DIM_W'(1);
						end
					endcase
				end else begin
					col_q <= col_q + bmp_prd_pkg::DIM_W'(n_load);
				end
			end
			if (rbc_next >= row_bytes) begin
				rbc_q     <= '0;
				col_q     <= '0;
				phase_q   <= '0;
				partial_q <= '0;
				line_q    <= (line_next >= h_eff) ? '0 : line_next[bmp_prd_pkg::COORD_W-1:0];
			end else begin
				rbc_q <= rbc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unp_busy_q <= 1'b0;
			unp_rem_q  <= '0;
		end else if (load) begin
			unp_busy_q <= 1'b1;
			unp_rem_q  <= n_load;
		end else if (issue) begin
			unp_rem_q <= unp_rem_q - 4'd1;
			if (unp_rem_q == 4'd1) begin
				unp_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unp_sh_q       <= data_byte;
			unp_col_q      <= col_q[bmp_prd_pkg::COORD_W-1:0];
			unp_row_q      <= bmp_prd_pkg::COORD_W'(h_eff - bmp_prd_pkg::DIM_W'(1)
				- {1'b0, line_q});
			unp_lastline_q <= ({1'b0, line_q} == h_eff - bmp_prd_pkg::DIM_W'(1));
			unp_direct_q   <= (depth_q == bmp_prd_pkg::DEPTH_24);
			unp_rgb_q      <= {data_byte, partial_q};
			unp_mode_q     <= depth_q;
		end else if (issue) begin
			unp_col_q <= unp_col_q + bmp_prd_pkg::COORD_W'(1);
			case (unp_mode_q)
				bmp_prd_pkg::DEPTH_1: unp_sh_q <= unp_sh_q << 1;
				bmp_prd_pkg::DEPTH_4: unp_sh_q <= unp_sh_q << 4;
				default:              unp_sh_q <= unp_sh_q;
			endcase
		end
	end

	always_comb begin
		case (unp_mode_q)
			bmp_prd_pkg::DEPTH_1: idx = {7'd0, unp_sh_q[7]};
			bmp_prd_pkg::DEPTH_4: idx = {4'd0, unp_sh_q[7:4]};
			default:              idx = unp_sh_q;
		endcase
		pix.direct = unp_direct_q;
		pix.rgb    = unp_rgb_q;
		pix.row    = unp_row_q;
		pix.col    = unp_col_q;
		pix.last   = (unp_rem_q == 4'd1);
		pix.done   = unp_lastline_q &&
			({1'b0, unp_col_q} == w_eff - bmp_prd_pkg::DIM_W'(1));
	end

	bmp_prd_ram #(
		.WIDTH(bmp_prd_pkg::COLOR_W),
		.DEPTH(bmp_prd_pkg::PALETTE_DEPTH)
	) u_colour_table (
		.clk   (clk),
		.we    (pal_we),
		.waddr (bmp_prd_pkg::PAL_AW'(palette_index)),
		.wdata ({palette_red, palette_green, palette_blue}),
		.raddr (bmp_prd_pkg::PAL_AW'(idx)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_q <= pix;
		end
	end

	assign pop = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (s1_valid_q) begin
				wr_ptr_q <= wr_ptr_q + bmp_prd_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bmp_prd_pkg::FIFO_AW'(1);
			end
			cnt_q <= cnt_q + bmp_prd_pkg::CNT_W'(s1_valid_q) - bmp_prd_pkg::CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			fifo_q[wr_ptr_q].rgb  <= s1_q.direct ? s1_q.rgb : ram_rdata;
			fifo_q[wr_ptr_q].row  <= s1_q.row;
			fifo_q[wr_ptr_q].col  <= s1_q.col;
			fifo_q[wr_ptr_q].last <= s1_q.last;
			fifo_q[wr_ptr_q].done <= s1_q.done;
		end
	end

	assign head         = fifo_q[rd_ptr_q];
	assign pixel_valid  = (cnt_q != '0);
	assign red          = head.rgb[23:16];
	assign green        = head.rgb[15:8];
	assign blue         = head.rgb[7:0];
	assign pixel_row    = head.row;
	assign pixel_column = head.col;
	assign last_of_byte = head.last;
	assign image_done   = head.done;

	`BMP_CHECK(a_fifo_bound, cnt_q <= bmp_prd_pkg::CNT_W'(bmp_prd_pkg::FIFO_DEPTH))
	`BMP_CHECK(a_stall_busy, !item_stall || unp_busy_q)
	`BMP_CHECK(a_busy_rem, !unp_busy_q || unp_rem_q != 4'd0)
	`BMP_CHECK_NEXT(a_issue_lands, issue, s1_valid_q)
	`BMP_CHECK_NEXT(a_last_frees, issue && unp_rem_q == 4'd1 && !load, !unp_busy_q)

endmodule

// ----- hdl/bmp_prd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bmp_prd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- tb/sv/tb_bmp_pixel_row_decoder_unit.sv -----
// Self-checking testbench of the BMP pixel row decoder: directed table, then random frames.
module tb_bmp_pixel_row_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int         PAL_USED  = 16;

	typedef struct packed {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [11:0] row;
		logic [11:0] col;
		logic        last;
		logic        done;
	} pix_exp_t;

	typedef enum logic {
		ROW_CFG  = 1'b0,
		ROW_ITEM = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [1:0]          idx;
		logic [12:0]         val;
		bmp_prd_pkg::func_t  fn;
		logic [7:0]          pidx;
		logic [7:0]          pb;
		logic [7:0]          pg;
		logic [7:0]          pr;
		logic [7:0]          db;
		logic                typed;
		pix_exp_t            want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [12:0]        cfg_data;
	logic               item_valid;
	logic               item_stall;
	bmp_prd_pkg::func_t func;
	logic [7:0]         palette_index;
	logic [7:0]         palette_blue;
	logic [7:0]         palette_green;
	logic [7:0]         palette_red;
	logic [7:0]         data_byte;
	logic               pixel_valid;
	logic               pixel_stall;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [11:0]        pixel_row;
	logic [11:0]        pixel_column;
	logic               last_of_byte;
	logic               image_done;

	bmp_pixel_row_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.palette_index(palette_index),
		.palette_blue (palette_blue),
		.palette_green(palette_green),
		.palette_red  (palette_red),
		.data_byte    (data_byte),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column),
		.last_of_byte (last_of_byte),
		.image_done   (image_done)
	);

	// decoder mirror
	bmp_prd_pkg::depth_t mode = bmp_prd_pkg::DEPTH_24;
	logic [12:0] width_reg = 13'd1;
	logic [12:0] height_reg = 13'd1;
	logic [23:0] colors [bmp_prd_pkg::PALETTE_DEPTH];
	int unsigned col_cnt = 0;
	int unsigned line_cnt = 0;
	int unsigned byte_cnt = 0;
	int unsigned comp_phase = 0;
	logic [15:0] partial = '0;

	pix_exp_t    due_pixels[$];
	pix_exp_t    fresh[$];
	stim_row_t   plan[$];
	int unsigned mismatches = 0;
	int unsigned rand_items = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;

	function automatic int unsigned eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > bmp_prd_pkg::MAX_WIDTH) return bmp_prd_pkg::MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_h();
		if (height_reg == 0) return 1;
		if (height_reg > bmp_prd_pkg::MAX_HEIGHT) return bmp_prd_pkg::MAX_HEIGHT;
		return height_reg;
	endfunction

	function automatic int unsigned bpp();
		case (mode)
			bmp_prd_pkg::DEPTH_1: return 1;
			bmp_prd_pkg::DEPTH_4: return 4;
			bmp_prd_pkg::DEPTH_8: return 8;
			default: return 24;
		endcase
	endfunction

	function automatic int unsigned row_span();
		return (((bpp() * eff_w() + 7) / 8) + 3) & ~32'd3;
	endfunction

	// 8-bit indices stay on palette entries that were written
	function automatic logic [7:0] pick_byte();
		if (mode != bmp_prd_pkg::DEPTH_8) return 8'($urandom_range(0, 255));
		if ($urandom_range(0, 7) == 0) return 8'hFF;
		return 8'($urandom_range(0, PAL_USED - 1));
	endfunction

	function automatic void restart_frame();
		col_cnt = 0;
		line_cnt = 0;
		byte_cnt = 0;
		comp_phase = 0;
		partial = '0;
	endfunction

	function automatic void apply_reg(logic [1:0] idx, logic [12:0] val);
		case (idx)
			bmp_prd_pkg::REG_DEPTH: mode = bmp_prd_pkg::depth_t'(val[1:0]);
			bmp_prd_pkg::REG_WIDTH: width_reg = val;
			bmp_prd_pkg::REG_HEIGHT: height_reg = val;
			default: return;
		endcase
		restart_frame();
	endfunction

	function automatic void emit_pixel(logic [23:0] rgb, int unsigned w, int unsigned h);
		pix_exp_t p;
		p.r = rgb[23:16];
		p.g = rgb[15:8];
		p.b = rgb[7:0];
		p.row = 12'(h - 1 - line_cnt);
		p.col = 12'(col_cnt);
		p.last = 1'b0;
		p.done = (col_cnt == w - 1) && (line_cnt == h - 1);
		fresh.insert(fresh.size(), p);
	endfunction

	// pixels that one data byte completes, left in fresh
	function automatic void decode_byte(logic [7:0] b);
		int unsigned w, h, bits, per, k, idx;
		w = eff_w();
		h = eff_h();
		bits = bpp();
		fresh.delete();
		if (col_cnt < w) begin
			if (bits == 24) begin
				if (comp_phase == 0) begin
					partial = {8'h00, b};
					comp_phase = 1;
				end else if (comp_phase == 1) begin
					partial[15:8] = b;
					comp_phase = 2;
				end else begin
					emit_pixel({b, partial}, w, h);
					col_cnt++;
					comp_phase = 0;
					partial = '0;
				end
			end else begin
				per = 8 / bits;
				for (k = 0; k < per && col_cnt < w; k++) begin
					idx = (32'(b) >> (8 - bits * (k + 1))) & ((32'd1 << bits) - 1);
					emit_pixel(colors[idx], w, h);
					col_cnt++;
				end
			end
			if (fresh.size() > 0) begin
				fresh[fresh.size() - 1].last = 1'b1;
			end
		end
		byte_cnt++;
		if (byte_cnt >= row_span()) begin
			byte_cnt = 0;
			col_cnt = 0;
			comp_phase = 0;
			partial = '0;
			line_cnt++;
			if (line_cnt >= h) line_cnt = 0;
		end
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [12:0] val);
		stim_row_t s;
		s = '0;
		s.kind = ROW_CFG;
		s.idx = idx;
		s.val = val;
		plan.insert(plan.size(), s);
	endfunction

	function automatic void add_pal(logic [7:0] pidx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		stim_row_t s;
		s = '0;
		s.kind = ROW_ITEM;
		s.fn = bmp_prd_pkg::FUNC_PALETTE;
		s.pidx = pidx;
		s.pr = r;
		s.pg = g;
		s.pb = b;
		plan.insert(plan.size(), s);
	endfunction

	function automatic void add_pix(logic [7:0] db);
		stim_row_t s;
		s = '0;
		s.kind = ROW_ITEM;
		s.fn = bmp_prd_pkg::FUNC_PIXEL;
		s.db = db;
		plan.insert(plan.size(), s);
	endfunction

	function automatic void add_pix_want(logic [7:0] db, logic [23:0] rgb, logic [11:0] row,
			logic [11:0] col, logic last, logic done);
		add_pix(db);
		plan[plan.size() - 1].typed = 1'b1;
		plan[plan.size() - 1].want = {rgb, row, col, last, done};
	endfunction

	task automatic offer(bmp_prd_pkg::func_t fn, logic [7:0] pi, logic [7:0] pb,
			logic [7:0] pg, logic [7:0] pr, logic [7:0] db, logic typed, pix_exp_t want);
		if (fn == bmp_prd_pkg::FUNC_PALETTE) begin
			colors[pi] = {pr, pg, pb};
		end else begin
			decode_byte(db);
			if (typed) due_pixels.insert(due_pixels.size(), want);
			else foreach (fresh[k]) due_pixels.insert(due_pixels.size(), fresh[k]);
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_valid <= 1'b1;
		func <= fn;
		palette_index <= pi;
		palette_blue <= pb;
		palette_green <= pg;
		palette_red <= pr;
		data_byte <= db;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic random_palette(logic [7:0] pi);
		offer(bmp_prd_pkg::FUNC_PALETTE, pi, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic pixel_stream(int unsigned n);
		for (int unsigned j = 0; j < n; j++) begin
			if ($urandom_range(0, 9) == 0) random_palette(8'($urandom_range(0, PAL_USED - 1)));
			offer(bmp_prd_pkg::FUNC_PIXEL, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), pick_byte(), 1'b0, '0);
			rand_items++;
		end
	endtask

	// input quiet, every pixel out, trailing padding beats flushed
	task automatic settle();
		item_valid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic configure(bmp_prd_pkg::depth_t d, logic [12:0] w, logic [12:0] h,
			bit spare);
		settle();
		if (spare) write_reg(REG_SPARE, 13'($urandom_range(0, 8191)));
		write_reg(bmp_prd_pkg::REG_DEPTH, 13'(d));
		write_reg(bmp_prd_pkg::REG_WIDTH, w);
		write_reg(bmp_prd_pkg::REG_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		pixel_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pixel_stall <= 1'b1;
				repeat (300) @(posedge clk);
				pixel_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				pixel_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				pixel_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : pixel_check
		pix_exp_t want_px;
		pix_exp_t got_px;
		if (arst_n && pixel_valid && !pixel_stall) begin
			got_px = {red, green, blue, pixel_row, pixel_column, last_of_byte, image_done};
			if (due_pixels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected pixel rgb=%h row=%0d col=%0d last=%b done=%b",
					$time, {red, green, blue}, pixel_row, pixel_column, last_of_byte,
					image_done);
			end else begin
				want_px = due_pixels.pop_front();
				if (got_px !== want_px) begin
					mismatches++;
					$display("%0t: pixel mismatch exp rgb=%h row=%0d col=%0d last=%b done=%b",
						$time, {want_px.r, want_px.g, want_px.b}, want_px.row, want_px.col,
						want_px.last, want_px.done);
					$display("%0t:                got rgb=%h row=%0d col=%0d last=%b done=%b",
						$time, {red, green, blue}, pixel_row, pixel_column, last_of_byte,
						image_done);
				end
			end
		end
	end

	initial begin
		bmp_prd_pkg::depth_t d;
		logic [12:0] w;
		logic [12:0] h;
		int unsigned rows;
		int unsigned n;
		int unsigned sel;
		int unsigned phase;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bmp_prd_pkg::REG_DEPTH;
		cfg_data <= '0;
		item_valid <= 1'b0;
		func <= bmp_prd_pkg::FUNC_PALETTE;
		palette_index <= '0;
		palette_blue <= '0;
		palette_green <= '0;
		palette_red <= '0;
		data_byte <= '0;

		// reset state: 24-bit, one pixel per row, one row
		add_pix(8'h00);
		add_pix(8'hFF);
		add_pix_want(8'h80, 24'h80FF00, 12'd0, 12'd0, 1'b1, 1'b1);
		add_pix(8'h55);
		add_pix(8'hFF);
		add_pix(8'hFF);
		add_pix_want(8'hFF, 24'hFFFFFF, 12'd0, 12'd0, 1'b1, 1'b1);
		add_pix(8'h00);
		add_pal(8'd0, 8'h00, 8'h00, 8'h00);
		add_pal(8'd1, 8'hFF, 8'hFF, 8'hFF);
		add_pal(8'd255, 8'h56, 8'h34, 8'h12);
		add_pal(8'd15, 8'hC3, 8'h5A, 8'hA5);
		// 1-bit, nine wide, two rows; spare index ignored
		add_cfg(bmp_prd_pkg::REG_DEPTH, 13'(bmp_prd_pkg::DEPTH_1));
		add_cfg(bmp_prd_pkg::REG_WIDTH, 13'd9);
		add_cfg(bmp_prd_pkg::REG_HEIGHT, 13'd2);
		add_cfg(REG_SPARE, 13'h1FFF);
		add_pix(8'hA5);
		add_pix_want(8'h80, 24'hFFFFFF, 12'd1, 12'd8, 1'b1, 1'b0);
		add_pix(8'h00);
		add_pix(8'h00);
		add_pix(8'h7F);
		add_pix_want(8'hFF, 24'hFFFFFF, 12'd0, 12'd8, 1'b1, 1'b1);
		add_pix(8'hFF);
		// 4-bit, width zero and height saturated
		add_cfg(bmp_prd_pkg::REG_DEPTH, 13'(bmp_prd_pkg::DEPTH_4));
		add_cfg(bmp_prd_pkg::REG_WIDTH, 13'd0);
		add_cfg(bmp_prd_pkg::REG_HEIGHT, 13'h1FFF);
		add_pix_want(8'hF0, 24'hC35AA5, 12'd4095, 12'd0, 1'b1, 1'b0);
		add_pix(8'h0F);
		// 8-bit, palette indices 255 and 1
		add_cfg(bmp_prd_pkg::REG_DEPTH, 13'(bmp_prd_pkg::DEPTH_8));
		add_cfg(bmp_prd_pkg::REG_WIDTH, 13'd2);
		add_cfg(bmp_prd_pkg::REG_HEIGHT, 13'd1);
		add_pix_want(8'hFF, 24'h563412, 12'd0, 12'd0, 1'b1, 1'b0);
		add_pix_want(8'h01, 24'hFFFFFF, 12'd0, 12'd1, 1'b1, 1'b1);
		add_pix(8'h00);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (i == 0 || plan[i - 1].kind != ROW_CFG) settle();
				write_reg(plan[i].idx, plan[i].val);
				if (i + 1 == plan.size() || plan[i + 1].kind != ROW_CFG) cfg_we <= 1'b0;
			end else begin
				offer(plan[i].fn, plan[i].pidx, plan[i].pb, plan[i].pg, plan[i].pr,
					plan[i].db, plan[i].typed, plan[i].want);
			end
		end

		for (int k = 0; k < PAL_USED; k++) random_palette(8'(k));

		// saturated row width, output held off long enough to back up the input
		configure(bmp_prd_pkg::DEPTH_1, 13'h1FFF, 13'd1, 1'b0);
		hold_req = 1'b1;
		pixel_stream(12);

		rand_items = 0;
		phase = 0;
		while (rand_items < 70) begin
			if (rand_items >= 55) calm = 1'b1;
			d = bmp_prd_pkg::depth_t'($urandom_range(0, 3));
			w = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(1, 10));
			sel = $urandom_range(0, 9);
			if (sel == 0) h = 13'd0;
			else if (sel == 1) h = 13'($urandom_range(4097, 8191));
			else h = 13'($urandom_range(1, 4));
			configure(d, w, h, $urandom_range(0, 3) == 0);
			rows = (eff_h() > 3) ? 2 : eff_h() + $urandom_range(0, 1);
			n = rows * row_span();
			if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n + 3);
			if (n > 24) n = 24;
			if (phase == 1) begin
				pixel_stream(n / 2);
				settle();
				n = n - n / 2;
			end
			pixel_stream(n);
			phase++;
		end

		settle();
		if (mismatches == 0 && due_pixels.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bmp_prd_pkg.sv
hdl/bmp_prd_ram.sv
hdl/bmp_pixel_row_decoder_unit.sv
tb/sv/tb_bmp_pixel_row_decoder_unit.sv
